// ----- design/tpnc_pkg.sv -----
// shared types, constants and rounding helpers for the torus evaluator
`timescale 1ns / 1ps
package tpnc_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // quarter wave polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42048;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  localparam logic [15:0] MAJOR_RST = 16'd8192;
  localparam logic [15:0] MINOR_RST = 16'd4096;

  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 2;
  localparam int RHO_W     = 18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAJOR = 2'd0,
    REG_MINOR = 2'd1
  } tpnc_reg_e;

  typedef struct packed {
    logic [15:0] angle_u;
    logic [15:0] angle_v;
  } tpnc_in_t;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] gauss_curv;
    logic signed [31:0] mean_curv;
    logic               config_invalid;
  } tpnc_out_t;

  // front to back: trig values and rho
  typedef struct packed {
    logic signed [15:0]      sin_u;
    logic signed [15:0]      cos_u;
    logic signed [15:0]      sin_v;
    logic signed [15:0]      cos_v;
    logic signed [RHO_W-1:0] rho;
  } tpnc_mid_t;

  // shift right by 14, round half away from zero
  function automatic logic signed [47:0] rshift14(input logic signed [47:0] x);
    logic signed [47:0] m;
    if (x >= 0) begin
      rshift14 = (x + 48'sd8192) >>> 14;
    end else begin
      m = (-x + 48'sd8192) >>> 14;
      rshift14 = -m;
    end
  endfunction

  function automatic logic signed [19:0] clamp20(input logic signed [47:0] x);
    if (x > 48'sd524287) begin
      clamp20 = 20'sh7FFFF;
    end else if (x < -48'sd524288) begin
      clamp20 = 20'sh80000;
    end else begin
      clamp20 = x[19:0];
    end
  endfunction

endpackage

// ----- design/tpnc_sine.sv -----
// five-stage pipelined Q1.14 sine of a phase word
`timescale 1ns / 1ps
module tpnc_sine #(
  parameter int ANGLE_BITS = tpnc_pkg::ANGLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [ANGLE_BITS-1:0]  phase_i,
  output logic signed [15:0]     sin_o
);
  import tpnc_pkg::*;

  localparam int FB = ANGLE_BITS - 2;

  logic [1:0]    quad;
  logic [FB-1:0] frac;
  logic [16:0]   t_raw, t_d;

  assign quad = phase_i[ANGLE_BITS-1:ANGLE_BITS-2];
  assign frac = phase_i[FB-1:0];

  generate
    if (FB >= 16) begin : g_shr
      assign t_raw = 17'(frac >> (FB - 16));
    end else begin : g_shl
      assign t_raw = 17'(frac) << (16 - FB);
    end
  endgenerate

  assign t_d = quad[0] ? (17'd65536 - t_raw) : t_raw;

  logic [16:0] t0_q, t1_q, t2_q, t3_q;
  logic        neg0_q, neg1_q, neg2_q, neg3_q;
  logic [16:0] sq1_q, sq2_q;
  logic [15:0] inner2_q;
  logic [16:0] mid3_q;
  logic signed [15:0] sin_q;

  logic [33:0] sq_full;
  logic [29:0] c_prod;
  logic [32:0] i_prod;
  logic [33:0] m_prod;
  logic [17:0] res, res_r;
  logic [15:0] mag;

  always_comb begin
    sq_full = t0_q * t0_q;
    c_prod  = SIN_C * sq1_q;
    i_prod  = inner2_q * sq2_q;
    m_prod  = t3_q * mid3_q;
    res     = m_prod[33:16];
    res_r   = (res + 18'd2) >> 2;
    mag     = (res_r > 18'(ONE_Q14)) ? ONE_Q14 : res_r[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q     <= t_d;
      neg0_q   <= quad[1];
      t1_q     <= t0_q;
      sq1_q    <= sq_full[32:16];
      neg1_q   <= neg0_q;
      t2_q     <= t1_q;
      sq2_q    <= sq1_q;
      inner2_q <= SIN_B - 16'(c_prod[29:16]);
      neg2_q   <= neg1_q;
      t3_q     <= t2_q;
      mid3_q   <= SIN_A - 17'(i_prod[32:16]);
      neg3_q   <= neg2_q;
      sin_q    <= neg3_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign sin_o = sin_q;

endmodule

// ----- design/tpnc_front.sv -----
// front: angle intake, four sine units and rho
`timescale 1ns / 1ps
module tpnc_front #(
  parameter int ANGLE_BITS = tpnc_pkg::ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpnc_pkg::tpnc_in_t  in_data_i,
  input  logic [15:0]         major_i,
  input  logic [15:0]         minor_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpnc_pkg::tpnc_mid_t out_data_o
);
  import tpnc_pkg::*;

  localparam int FL = 7;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [FL-1:0] vld_q;
  logic          en;

  assign en         = !vld_q[FL-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[FL-2:0], in_valid_i};
    end
  end

  logic [ANGLE_BITS-1:0] ph_u, ph_v;
  logic signed [15:0] su, cu, sv, cv;

  assign ph_u = ANGLE_BITS'(in_data_i.angle_u);
  assign ph_v = ANGLE_BITS'(in_data_i.angle_v);

  tpnc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_u (
    .clk_i(clk_i), .en_i(en), .phase_i(ph_u), .sin_o(su));
  tpnc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_u (
    .clk_i(clk_i), .en_i(en), .phase_i(ph_u + QUARTER), .sin_o(cu));
  tpnc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_v (
    .clk_i(clk_i), .en_i(en), .phase_i(ph_v), .sin_o(sv));
  tpnc_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_v (
    .clk_i(clk_i), .en_i(en), .phase_i(ph_v + QUARTER), .sin_o(cv));

  tpnc_mid_t       trig5_q, mid6_q, mid_d;
  logic signed [32:0] rcv5_q;
  logic signed [47:0] rcv_rnd;

  assign rcv_rnd = rshift14(48'(rcv5_q));

  // trig values pass through, rho filled in
  always_comb begin
    mid_d     = trig5_q;
    mid_d.rho = $signed({2'b00, major_i}) + RHO_W'(rcv_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trig5_q.sin_u <= su;
      trig5_q.cos_u <= cu;
      trig5_q.sin_v <= sv;
      trig5_q.cos_v <= cv;
      trig5_q.rho   <= '0;
      rcv5_q        <= $signed({1'b0, minor_i}) * cv;
      mid6_q        <= mid_d;
    end
  end

  assign out_valid_o = vld_q[FL-1];
  assign out_data_o  = mid6_q;

endmodule

// ----- design/tpnc_fifo.sv -----
// small register queue between front and back
`timescale 1ns / 1ps
module tpnc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpnc_pkg::tpnc_mid_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpnc_pkg::tpnc_mid_t out_data_o
);
  import tpnc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  tpnc_mid_t       mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CW'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(QDEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ptr_inc(wr_q);
      if (pop)  rd_q <= ptr_inc(rd_q);
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QDEPTH)) else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + CW'(1)) else $error("queue count missed a push");
  a_cnt_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - CW'(1)) else $error("queue count missed a pop");

endmodule

// ----- design/tpnc_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
module tpnc_div #(
  parameter int NW = 48,
  parameter int DW = 35,
  parameter int QB = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quo_o,
  output logic          ovf_o
);
  localparam int HW = NW - QB;
  localparam int CMPW = (HW > DW) ? HW : DW;

  logic [DW-1:0] rem_q [QB+1];
  logic [QB-1:0] lo_q  [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [DW-1:0] den_q [QB+1];
  logic          ovf_q [QB+1];

  logic [HW-1:0] hi;
  assign hi = num_i[NW-1:QB];

  // first register loads the operands and flags a quotient that would not fit in QB bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(hi);
      lo_q[0]  <= num_i[QB-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= CMPW'(hi) >= CMPW'(den_i);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [DW:0] trial;
    logic        take;
    assign trial = {rem_q[k-1], lo_q[k-1][QB-1]};
    assign take  = trial >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? DW'(trial - {1'b0, den_q[k-1]}) : trial[DW-1:0];
        lo_q[k]  <= lo_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][QB-2:0], take};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

// ----- design/tpnc_back.sv -----
// back: products, rounding, curvature division and output register
`timescale 1ns / 1ps
module tpnc_back #(
  parameter int FRAC_BITS = tpnc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpnc_pkg::tpnc_mid_t in_data_i,
  input  logic [15:0]         major_i,
  input  logic [15:0]         minor_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpnc_pkg::tpnc_out_t out_data_o
);
  import tpnc_pkg::*;

  localparam int GW = 2 * FRAC_BITS + 17;
  localparam int MW = FRAC_BITS + 35;
  localparam int NW = ((GW > MW) ? GW : MW) + 1;
  localparam int DW = 35;
  localparam int QB = 33;
  localparam int DL = QB + 1;
  localparam int BL = DL + 3;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               g_neg;
    logic               m_neg;
    logic               dzero;
    logic               cfg_bad;
  } side_t;

  logic [BL-1:0] vld_q;
  logic          en;

  assign en         = !vld_q[BL-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BL-2:0], in_valid_i};
    end
  end

  // products
  logic signed [33:0] px0_q, py0_q;
  logic signed [32:0] pz0_q, rcv0_q;
  logic signed [31:0] nx0_q, ny0_q;
  logic signed [34:0] den0_q;
  logic signed [15:0] cv0_q, sv0_q;
  logic signed [16:0] r_s;

  assign r_s = $signed({1'b0, minor_i});

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q  <= in_data_i.rho * in_data_i.cos_u;
      py0_q  <= in_data_i.rho * in_data_i.sin_u;
      pz0_q  <= r_s * in_data_i.sin_v;
      rcv0_q <= r_s * in_data_i.cos_v;
      nx0_q  <= in_data_i.cos_v * in_data_i.cos_u;
      ny0_q  <= in_data_i.cos_v * in_data_i.sin_u;
      den0_q <= r_s * in_data_i.rho;
      cv0_q  <= in_data_i.cos_v;
      sv0_q  <= in_data_i.sin_v;
    end
  end

  // rounding, signs and rounded numerators
  side_t              side_d;
  logic [DW-1:0]      dmag;
  logic [14:0]        cv_mag;
  logic signed [35:0] mn_s;
  logic [35:0]        mn_mag;
  logic [NW-1:0]      ung_d, unm_d;

  always_comb begin
    side_d.px      = clamp20(rshift14(48'(px0_q)));
    side_d.py      = clamp20(rshift14(48'(py0_q)));
    side_d.pz      = clamp20(rshift14(48'(pz0_q)));
    side_d.nx      = 16'(rshift14(48'(nx0_q)));
    side_d.ny      = 16'(rshift14(48'(ny0_q)));
    side_d.nz      = sv0_q;
    side_d.dzero   = (den0_q == '0);
    side_d.cfg_bad = (minor_i == '0) || (minor_i >= major_i);
    dmag           = den0_q[34] ? DW'(-den0_q) : DW'(den0_q);
    cv_mag         = cv0_q[15] ? 15'(-cv0_q) : 15'(cv0_q);
    mn_s           = $signed(36'(major_i) << 14) + (36'(rcv0_q) <<< 1);
    mn_mag         = mn_s[35] ? 36'(-mn_s) : 36'(mn_s);
    side_d.g_neg   = cv0_q[15] != den0_q[34];
    side_d.m_neg   = mn_s[35] != den0_q[34];
    ung_d          = (NW'(cv_mag) << (2 * FRAC_BITS + 2)) + NW'(dmag >> 1);
    unm_d          = (NW'(mn_mag) << (FRAC_BITS + 1)) + NW'(dmag >> 1);
  end

  side_t         side1_q;
  logic [NW-1:0] ung1_q, unm1_q;
  logic [DW-1:0] dmag1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side_d;
      ung1_q  <= ung_d;
      unm1_q  <= unm_d;
      dmag1_q <= dmag;
    end
  end

  logic [QB-1:0] gq, mq;
  logic          g_ovf, m_ovf;

  tpnc_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_gauss (
    .clk_i(clk_i), .en_i(en), .num_i(ung1_q), .den_i(dmag1_q),
    .quo_o(gq), .ovf_o(g_ovf));

  tpnc_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_mean (
    .clk_i(clk_i), .en_i(en), .num_i(unm1_q), .den_i(dmag1_q),
    .quo_o(mq), .ovf_o(m_ovf));

  side_t side_q [DL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side1_q;
      for (int i = 1; i < DL; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  function automatic logic signed [31:0] sat_quo(input logic [QB-1:0] q, input logic ovf,
                                                 input logic neg, input logic zero);
    logic [QB-1:0] qn;
    qn = -q;
    if (zero) begin
      sat_quo = '0;
    end else if (!neg) begin
      sat_quo = (ovf || q > QB'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      sat_quo = (ovf || q > QB'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(qn[31:0]);
    end
  endfunction

  tpnc_out_t out_q;
  side_t     sl;

  assign sl = side_q[DL-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.pos_x          <= sl.px;
      out_q.pos_y          <= sl.py;
      out_q.pos_z          <= sl.pz;
      out_q.normal_x       <= sl.nx;
      out_q.normal_y       <= sl.ny;
      out_q.normal_z       <= sl.nz;
      out_q.gauss_curv     <= sat_quo(gq, g_ovf, sl.g_neg, sl.dzero);
      out_q.mean_curv      <= sat_quo(mq, m_ovf, sl.m_neg, sl.dzero);
      out_q.config_invalid <= sl.cfg_bad;
    end
  end

  assign out_valid_o = vld_q[BL-1];
  assign out_data_o  = out_q;

endmodule

// ----- design/torus_point_normal_curvature_top.sv -----
// torus point, normal and curvature evaluator: top level
// throughput: one angle pair per cycle while the result channel is ready, set by the fully
//   pipelined sine units and the two one-bit-per-stage curvature dividers
// reset: radius registers return to R = 2.0 and r = 1.0, pipelines and queue empty
// no clearing pass; items are taken from the first cycle after reset
`timescale 1ns / 1ps
module torus_point_normal_curvature_top #(
  parameter int ANGLE_BITS = tpnc_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = tpnc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // angle input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tpnc_pkg::tpnc_in_t                in_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tpnc_pkg::tpnc_out_t               out_data_o,
  // register write port
  input  logic                              cfg_we_i,
  input  logic [tpnc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [15:0]                       cfg_data_i
);
  import tpnc_pkg::*;

  // radius registers, Q4.12
  logic [15:0] major_q, minor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q <= MAJOR_RST;
      minor_q <= MINOR_RST;
    end else if (cfg_we_i) begin
      // writes to unknown indexes are dropped
      if (cfg_idx_i == REG_MAJOR) major_q <= cfg_data_i;
      if (cfg_idx_i == REG_MINOR) minor_q <= cfg_data_i;
    end
  end

  // front: sine and cosine of both angles, then rho
  logic      f_valid, f_ready;
  tpnc_mid_t f_data;

  tpnc_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .major_i     (major_q),
    .minor_i     (minor_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  // queue decouples the two stall domains
  logic      b_valid, b_ready;
  tpnc_mid_t b_data;

  tpnc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .out_data_o  (b_data)
  );

  // back: point, normal, curvature division, output register
  tpnc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .in_data_i   (b_data),
    .major_i     (major_q),
    .minor_i     (minor_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
